@@ rtl/hvn_pkg.sv @@
// Shared constants and types of the heightmap vertex normal pipeline.
`timescale 1ns / 1ps
`default_nettype none

package hvn_pkg;

  localparam int HEIGHT_BITS = 8;
  localparam int FRAC_BITS   = 14;
  localparam int DIV_W       = 8;
  localparam int OUT_W       = 16;

  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(10);

  localparam int DIFF_W  = HEIGHT_BITS + 1;
  localparam int SUM_W   = HEIGHT_BITS + 4;
  localparam int MAG_W   = HEIGHT_BITS + 3;
  localparam int CNT_W   = 3;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int S_W     = SQ_W + 2;
  localparam int N_W     = FRAC_BITS + 1;
  localparam int T_SHIFT = 2 * FRAC_BITS + 2;
  localparam int R_W     = S_W + 2 * N_W + 3;
  localparam int B_W     = S_W + N_W + 2;

  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + N_W + 1;

  typedef struct packed {
    logic [S_W-1:0]        s;
    logic signed [R_W-1:0] r0_x;
    logic signed [R_W-1:0] r0_y;
    logic signed [R_W-1:0] r0_z;
  } front_t;

  typedef struct packed {
    logic neg_x;
    logic neg_z;
    logic no_faces;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/hvn_front.sv @@
// Front stages: face sums, component magnitudes, squares and the start remainders.
`timescale 1ns / 1ps
`default_nettype none

module hvn_front import hvn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DIV_W-1:0]       div_i,
  input  logic [HEIGHT_BITS-1:0] center_height_i,
  input  logic [HEIGHT_BITS-1:0] left_height_i,
  input  logic [HEIGHT_BITS-1:0] right_height_i,
  input  logic [HEIGHT_BITS-1:0] below_height_i,
  input  logic [HEIGHT_BITS-1:0] above_height_i,
  input  logic [HEIGHT_BITS-1:0] below_right_height_i,
  input  logic [HEIGHT_BITS-1:0] above_left_height_i,
  input  logic                   has_left_i,
  input  logic                   has_right_i,
  input  logic                   has_below_i,
  input  logic                   has_above_i,
  output front_t                 front_o,
  output side_t                  side_o
);

  function automatic logic signed [DIFF_W-1:0] hdiff(input logic [HEIGHT_BITS-1:0] a,
                                                     input logic [HEIGHT_BITS-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  logic signed [SUM_W-1:0] sx_d, sz_d, sx_q, sz_q;
  logic [CNT_W-1:0]        cnt_d, cnt_q;

  always_comb begin
    logic signed [DIFF_W-1:0] d_vr, d_lv, d_lal, d_ala, d_va, d_bbr, d_bv, d_brr;
    logic f_ra, f_la, f_rb, f_lb;
    d_vr  = hdiff(center_height_i, right_height_i);
    d_lv  = hdiff(left_height_i, center_height_i);
    d_lal = hdiff(left_height_i, above_left_height_i);
    d_ala = hdiff(above_left_height_i, above_height_i);
    d_va  = hdiff(center_height_i, above_height_i);
    d_bbr = hdiff(below_height_i, below_right_height_i);
    d_bv  = hdiff(below_height_i, center_height_i);
    d_brr = hdiff(below_right_height_i, right_height_i);
    f_ra  = has_right_i & has_above_i;
    f_la  = has_left_i & has_above_i;
    f_rb  = has_right_i & has_below_i;
    f_lb  = has_left_i & has_below_i;
    sx_d  = '0;
    sz_d  = '0;
    if (f_ra) begin
      sx_d = sx_d + SUM_W'(d_vr);
      sz_d = sz_d + SUM_W'(d_va);
    end
    if (f_la) begin
      sx_d = sx_d + SUM_W'(d_lv) + SUM_W'(d_ala);
      sz_d = sz_d + SUM_W'(d_lal) + SUM_W'(d_va);
    end
    if (f_rb) begin
      sx_d = sx_d + SUM_W'(d_bbr) + SUM_W'(d_vr);
      sz_d = sz_d + SUM_W'(d_bv) + SUM_W'(d_brr);
    end
    if (f_lb) begin
      sx_d = sx_d + SUM_W'(d_lv);
      sz_d = sz_d + SUM_W'(d_bv);
    end
    cnt_d = CNT_W'(f_ra) + CNT_W'({f_la, 1'b0}) + CNT_W'({f_rb, 1'b0}) + CNT_W'(f_lb);
  end

  logic [DIV_W-1:0]             d_eff;
  logic [CNT_W+DIV_W-1:0]       ay_prod;
  logic [MAG_W-1:0]             ax_q, ay_q, az_q;
  logic                         neg_x2_q, neg_z2_q, nf2_q;
  logic [SQ_W-1:0]              sqx_q, sqy_q, sqz_q;
  logic                         neg_x3_q, neg_z3_q, nf3_q;
  logic [S_W-1:0]               s_sum;
  front_t                       front_q;
  side_t                        side_q;

  assign d_eff   = (div_i == '0) ? DIV_W'(1) : div_i;
  assign ay_prod = (CNT_W+DIV_W)'(cnt_q) * (CNT_W+DIV_W)'(d_eff);
  assign s_sum   = S_W'(sqx_q) + S_W'(sqy_q) + S_W'(sqz_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q     <= sx_d;
      sz_q     <= sz_d;
      cnt_q    <= cnt_d;

      ax_q     <= sx_q[SUM_W-1] ? MAG_W'(-sx_q) : MAG_W'(sx_q);
      az_q     <= sz_q[SUM_W-1] ? MAG_W'(-sz_q) : MAG_W'(sz_q);
      ay_q     <= MAG_W'(ay_prod);
      neg_x2_q <= sx_q[SUM_W-1];
      neg_z2_q <= sz_q[SUM_W-1];
      nf2_q    <= (cnt_q == '0);

      sqx_q    <= SQ_W'(ax_q) * SQ_W'(ax_q);
      sqy_q    <= SQ_W'(ay_q) * SQ_W'(ay_q);
      sqz_q    <= SQ_W'(az_q) * SQ_W'(az_q);
      neg_x3_q <= neg_x2_q;
      neg_z3_q <= neg_z2_q;
      nf3_q    <= nf2_q;

      front_q.s    <= s_sum;
      front_q.r0_x <= $signed(R_W'(sqx_q) << T_SHIFT) - $signed(R_W'(s_sum));
      front_q.r0_y <= $signed(R_W'(sqy_q) << T_SHIFT) - $signed(R_W'(s_sum));
      front_q.r0_z <= $signed(R_W'(sqz_q) << T_SHIFT) - $signed(R_W'(s_sum));
      side_q.neg_x    <= neg_x3_q;
      side_q.neg_z    <= neg_z3_q;
      side_q.no_faces <= nf3_q;
    end
  end

  assign front_o = front_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

@@ rtl/hvn_unit_mag.sv @@
// Digit pipeline that finds one rounded unit-vector magnitude, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module hvn_unit_mag import hvn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [S_W-1:0]        s_i,
  input  logic signed [R_W-1:0] r0_i,
  output logic [N_W-1:0]        mag_o
);

  // The remainder holds T - (2n-1)^2 * S and b holds (2n-1) * S for the bits found so far.
  logic signed [R_W-1:0] r_q [N_W-1];
  logic signed [B_W-1:0] b_q [N_W-1];
  logic [S_W-1:0]        s_q [N_W-1];
  logic [N_W-1:0]        n_q [N_W];

  for (genvar i = 0; i < N_W; i++) begin : g_stage
    localparam int J = N_W - 1 - i;
    logic signed [R_W-1:0] r_in, delta, r_try;
    logic signed [B_W-1:0] b_in;
    logic [S_W-1:0]        s_in;
    logic [N_W-1:0]        n_in;
    logic                  take;

    if (i == 0) begin : g_first
      assign r_in = r0_i;
      assign b_in = -$signed(B_W'(s_i));
      assign s_in = s_i;
      assign n_in = '0;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign b_in = b_q[i-1];
      assign s_in = s_q[i-1];
      assign n_in = n_q[i-1];
    end

    assign delta = (R_W'(b_in) <<< (J + 2)) + $signed(R_W'(s_in) << (2 * J + 2));
    assign r_try = r_in - delta;
    assign take  = ~r_try[R_W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i] <= n_in | (take ? (N_W'(1) << J) : N_W'(0));
      end
    end

    if (i < N_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i] <= take ? r_try : r_in;
          b_q[i] <= take ? b_in + $signed(B_W'(s_in) << (J + 1)) : b_in;
          s_q[i] <= s_in;
        end
      end
    end
  end

  assign mag_o = n_q[N_W-1];

endmodule

`default_nettype wire

@@ rtl/heightmap_vertex_normal.sv @@
// Top level of the heightmap vertex normal pipeline.
// An input beat runs through the front stages, the magnitude stages and the output register.
// One vertex per cycle unless stalled; each of the 15 magnitude stages settles one result bit.
// A stalled output holds every stage in place; the input is ready whenever the output moves.
// Reset clears all valid bits and sets the height divisor to 10; the pipeline data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_vertex_normal import hvn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [DIV_W-1:0]        height_divisor_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [HEIGHT_BITS-1:0]  center_height_i,
  input  logic [HEIGHT_BITS-1:0]  left_height_i,
  input  logic [HEIGHT_BITS-1:0]  right_height_i,
  input  logic [HEIGHT_BITS-1:0]  below_height_i,
  input  logic [HEIGHT_BITS-1:0]  above_height_i,
  input  logic [HEIGHT_BITS-1:0]  below_right_height_i,
  input  logic [HEIGHT_BITS-1:0]  above_left_height_i,
  input  logic                    has_left_i,
  input  logic                    has_right_i,
  input  logic                    has_below_i,
  input  logic                    has_above_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] normal_x_o,
  output logic signed [OUT_W-1:0] normal_y_o,
  output logic signed [OUT_W-1:0] normal_z_o,
  output logic                    no_faces_o
);

  localparam int SAT_W   = ((N_W > OUT_W) ? N_W : OUT_W) + 1;
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  function automatic logic signed [OUT_W-1:0] apply_sign(input logic [N_W-1:0] mag,
                                                         input logic neg);
    logic signed [SAT_W-1:0] v;
    v = $signed(SAT_W'(mag));
    if (neg) begin
      v = -v;
    end
    if (v > SAT_W'(OUT_MAX)) begin
      v = SAT_W'(OUT_MAX);
    end else if (v < SAT_W'(OUT_MIN)) begin
      v = SAT_W'(OUT_MIN);
    end
    return OUT_W'(v);
  endfunction

  logic [DIV_W-1:0]      div_q;
  logic                  en;
  logic [PIPE_DEPTH-1:0] v_q;
  front_t                front;
  side_t                 side_f;
  side_t                 side_q [N_W];
  logic [N_W-1:0]        mag_x, mag_y, mag_z;
  logic signed [OUT_W-1:0] nx_q, ny_q, nz_q;
  logic                  nf_q;

  assign cfg_ready_o = 1'b1;
  assign en          = ~v_q[PIPE_DEPTH-1] | out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DIV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      div_q <= height_divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  hvn_front u_front (
    .clk_i                (clk_i),
    .en_i                 (en),
    .div_i                (div_q),
    .center_height_i      (center_height_i),
    .left_height_i        (left_height_i),
    .right_height_i       (right_height_i),
    .below_height_i       (below_height_i),
    .above_height_i       (above_height_i),
    .below_right_height_i (below_right_height_i),
    .above_left_height_i  (above_left_height_i),
    .has_left_i           (has_left_i),
    .has_right_i          (has_right_i),
    .has_below_i          (has_below_i),
    .has_above_i          (has_above_i),
    .front_o              (front),
    .side_o               (side_f)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_f;
      for (int k = 1; k < N_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  hvn_unit_mag u_mag_x (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (front.s),
    .r0_i  (front.r0_x),
    .mag_o (mag_x)
  );

  hvn_unit_mag u_mag_y (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (front.s),
    .r0_i  (front.r0_y),
    .mag_o (mag_y)
  );

  hvn_unit_mag u_mag_z (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (front.s),
    .r0_i  (front.r0_z),
    .mag_o (mag_z)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      nf_q <= side_q[N_W-1].no_faces;
      if (side_q[N_W-1].no_faces) begin
        nx_q <= '0;
        ny_q <= '0;
        nz_q <= '0;
      end else begin
        nx_q <= apply_sign(mag_x, side_q[N_W-1].neg_x);
        ny_q <= apply_sign(mag_y, 1'b0);
        nz_q <= apply_sign(mag_z, side_q[N_W-1].neg_z);
      end
    end
  end

  assign out_valid_o = v_q[PIPE_DEPTH-1];
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign no_faces_o  = nf_q;

  a_no_faces_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_faces_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("no-face beat carries a nonzero normal");

  a_up_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !no_faces_o |-> normal_y_o > 0)
    else $error("up component of a face normal sum is not positive");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o >= -16384 && normal_x_o <= 16384 &&
                    normal_z_o >= -16384 && normal_z_o <= 16384 && normal_y_o <= 16384)
    else $error("normal component beyond unit magnitude");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off while the output is free");

endmodule

`default_nettype wire
